// ===== design/adc_scan_ema_filter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADC_SCAN_EMA_FILTER_CORE_ASSERT_SVH
`define ADC_SCAN_EMA_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define ASEF_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define ASEF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASEF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASEF_ASSERT(lbl, expr)
`define ASEF_ASSERT_IMP(lbl, ante, cons)
`define ASEF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== design/asef_pkg.sv =====
// ----------------------------------------------------------------------------
// asef_pkg
// Codes, field widths and item types of the ADC scan filter.
// ----------------------------------------------------------------------------
`default_nettype none

package asef_pkg;

  localparam int ACT_W      = 2;
  localparam int SMP_W      = 12;
  localparam int CH_W       = 5;
  localparam int SH_W       = 5;
  localparam int VAL_W      = 31;
  localparam int ST_W       = 2;
  localparam int SAMPLE_POS = 19;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

  localparam logic [SH_W-1:0] FSH_RST = 5'd9;
  localparam logic [SH_W-1:0] OSH_RST = 5'd15;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [SH_W-1:0]  out_shift;
    logic [SH_W-1:0]  filter_shift;
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value;
    logic [CH_W-1:0]  next_channel;
  } result_t;

endpackage

`default_nettype wire

// ===== design/adc_scan_ema_filter_core.sv =====
// ----------------------------------------------------------------------------
// adc_scan_ema_filter_core
// Scanning ADC post-processor with per-channel shift-based EMA filters.
// Takes one item per clock when the result side is not stalled; each item
// passes the input register, then the result register, before its result is
// presented on out_*; a result-side stall can hold it between the two. The
// rate is set by the single read-modify-write of one channel accumulator
// done in the stage between the two registers.
// Add items append a scan slot, sample items filter a conversion into the
// current slot's channel and return the next channel to convert, read items
// return a channel accumulator shifted right by its output shift.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adc_scan_ema_filter_core_assert.svh"

module adc_scan_ema_filter_core
  import asef_pkg::*;
#(
  parameter int CHANNELS = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sample[11:0], channel[16:12], filter_shift[21:17], out_shift[26:22], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // next_channel[4:0], value[35:5], status[37:36], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int RES_W = $bits(result_t);
  localparam logic [CH_W:0]    CH_LIM  = (CH_W + 1)'(CHANNELS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CHANNELS);

  logic             s1_valid_r, s1_valid_nxt;
  item_t            s1_item_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r, out_res_nxt;

  logic [CH_W-1:0]  slot_ch_r  [CHANNELS];
  logic [SH_W-1:0]  slot_fsh_r [CHANNELS];
  logic [SH_W-1:0]  ch_osh_r   [CHANNELS];
  logic [VAL_W-1:0] ch_acc_r   [CHANNELS];
  logic [CNT_W-1:0] slot_cnt_r, slot_cnt_nxt;
  logic [IDX_W-1:0] scan_pos_r, scan_pos_nxt;
  logic [CH_W-1:0]  cur_ch_r, cur_ch_nxt;
  logic [SH_W-1:0]  cur_fsh_r, cur_fsh_nxt;

  logic             s1_adv, s1_fire, in_fire;
  logic             ch_ok, tbl_full;
  logic [IDX_W-1:0] ch_idx, slot_idx, acc_idx, pos_next;
  logic [CNT_W-1:0] pos_p1;
  logic             pos_wrap;
  logic [VAL_W-1:0] acc_rd, acc_new, rd_val;
  logic [VAL_W-1:0] smp_x;
  logic signed [VAL_W:0]   diff, step;
  logic [VAL_W+1:0] acc_sum;
  logic             slot_we, acc_we;

  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, out_res_r};

  assign ch_ok    = {1'b0, s1_item_r.channel} < CH_LIM;
  assign ch_idx   = s1_item_r.channel[IDX_W-1:0];
  assign tbl_full = slot_cnt_r >= CNT_MAX;
  assign slot_idx = slot_cnt_r[IDX_W-1:0];

  assign acc_idx = (s1_item_r.action == ACT_SAMPLE) ? cur_ch_r[IDX_W-1:0] : ch_idx;
  assign acc_rd  = ch_acc_r[acc_idx];
  assign rd_val  = acc_rd >> ch_osh_r[ch_idx];

  assign smp_x   = {s1_item_r.sample, {SAMPLE_POS{1'b0}}};
  assign diff    = $signed({1'b0, smp_x}) - $signed({1'b0, acc_rd});
  assign step    = diff >>> cur_fsh_r;
  assign acc_sum = {2'b00, acc_rd} + {step[VAL_W], step};
  assign acc_new = acc_sum[VAL_W-1:0];

  assign pos_p1   = CNT_W'(scan_pos_r) + CNT_W'(1);
  assign pos_wrap = pos_p1 >= slot_cnt_r;
  assign pos_next = pos_wrap ? '0 : pos_p1[IDX_W-1:0];

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_res_nxt  = '0;
    slot_we      = 1'b0;
    acc_we       = 1'b0;
    slot_cnt_nxt = slot_cnt_r;
    scan_pos_nxt = scan_pos_r;
    cur_ch_nxt   = cur_ch_r;
    cur_fsh_nxt  = cur_fsh_r;
    case (s1_item_r.action)
      ACT_ADD: begin
        if (tbl_full) begin
          out_res_nxt.status = ST_FULL;
        end else if (!ch_ok) begin
          out_res_nxt.status = ST_BAD;
        end else begin
          slot_we      = s1_fire;
          slot_cnt_nxt = slot_cnt_r + CNT_W'(1);
          if (CNT_W'(scan_pos_r) == slot_cnt_r) begin
            cur_ch_nxt  = s1_item_r.channel;
            cur_fsh_nxt = s1_item_r.filter_shift;
          end
        end
      end
      ACT_SAMPLE: begin
        acc_we                   = s1_fire;
        scan_pos_nxt             = pos_next;
        cur_ch_nxt               = slot_ch_r[pos_next];
        cur_fsh_nxt              = slot_fsh_r[pos_next];
        out_res_nxt.next_channel = slot_ch_r[pos_next];
      end
      ACT_READ: begin
        if (ch_ok) begin
          out_res_nxt.value = rd_val;
        end else begin
          out_res_nxt.status = ST_BAD;
        end
      end
      default: begin
        out_res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      slot_cnt_r  <= '0;
      scan_pos_r  <= '0;
      cur_ch_r    <= '0;
      cur_fsh_r   <= FSH_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        slot_cnt_r <= slot_cnt_nxt;
        scan_pos_r <= scan_pos_nxt;
        cur_ch_r   <= cur_ch_nxt;
        cur_fsh_r  <= cur_fsh_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.action       <= in_tuser;
      s1_item_r.sample       <= in_tdata[11:0];
      s1_item_r.channel      <= in_tdata[16:12];
      s1_item_r.filter_shift <= in_tdata[21:17];
      s1_item_r.out_shift    <= in_tdata[26:22];
    end
    if (s1_fire) begin
      out_res_r <= out_res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slot_ch_r[i]  <= '0;
        slot_fsh_r[i] <= FSH_RST;
        ch_osh_r[i]   <= OSH_RST;
        ch_acc_r[i]   <= '0;
      end
    end else begin
      if (slot_we) begin
        slot_ch_r[slot_idx]  <= s1_item_r.channel;
        slot_fsh_r[slot_idx] <= s1_item_r.filter_shift;
        ch_osh_r[ch_idx]     <= s1_item_r.out_shift;
      end
      if (acc_we) begin
        ch_acc_r[acc_idx] <= acc_new;
      end
    end
  end

  `ASEF_ASSERT(a_cnt_range, slot_cnt_r <= CNT_MAX)
  `ASEF_ASSERT(a_pos_range, (scan_pos_r == '0) || (CNT_W'(scan_pos_r) < slot_cnt_r))
  `ASEF_ASSERT(a_cur_slot, (cur_ch_r == slot_ch_r[scan_pos_r]) &&
               (cur_fsh_r == slot_fsh_r[scan_pos_r]))
  `ASEF_ASSERT_NXT(a_fire_out, s1_fire, out_valid_r)
  `ASEF_ASSERT_IMP(a_err_zero, out_valid_r && (out_res_r.status != ST_OK),
                   (out_res_r.value == '0) && (out_res_r.next_channel == '0))

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of adc_scan_ema_filter_core. A queue of add, sample,
// read and idle items is driven through in_*, each accepted item is run
// through a local model of the slot table and channel accumulators, and every
// result on out_* is compared field by field against the oldest prediction.
// Both sides stall at random; the result side also holds off for a long
// stretch so the core backs up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import asef_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS    = 18;
  localparam int RAND_ITEMS  = 1150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_START  = 300;
  localparam int HOLD_LEN    = 150;
  localparam int CALM_START  = 700;
  localparam int CALM_END    = 1000;
  localparam int SETTLE      = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [ACT_W-1:0]      in_tuser = ACT_NOP;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // model state
  logic [CH_W-1:0]  mdl_slot_ch  [CHANNELS];
  logic [SH_W-1:0]  mdl_slot_fsh [CHANNELS];
  logic [SH_W-1:0]  mdl_out_sh   [CHANNELS];
  logic [VAL_W-1:0] mdl_acc      [CHANNELS];
  int unsigned      mdl_slots;
  int unsigned      mdl_pos;

  item_t   pending_items[$];
  result_t expected_results[$];
  item_t   drv_item;
  bit      in_fire = 1'b0;
  bit      calm;
  bit      hold_done = 1'b0;
  int      hold_left = 0;
  int      cyc = 0;
  int      mismatches = 0;

  adc_scan_ema_filter_core #(.CHANNELS(CHANNELS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign calm = (cyc >= CALM_START) && (cyc < CALM_END);

  function automatic item_t make_item(logic [ACT_W-1:0] act, int unsigned smp,
                                      int unsigned ch, int unsigned fsh,
                                      int unsigned osh);
    item_t it;
    it.action       = act;
    it.sample       = smp[SMP_W-1:0];
    it.channel      = ch[CH_W-1:0];
    it.filter_shift = fsh[SH_W-1:0];
    it.out_shift    = osh[SH_W-1:0];
    return it;
  endfunction

  function automatic result_t predict_scan(item_t it);
    result_t     r;
    int unsigned p;
    int unsigned c;
    longint      x;
    longint      a;
    r = '0;
    case (it.action)
      ACT_ADD: begin
        if (mdl_slots >= CHANNELS) begin
          r.status = ST_FULL;
        end else if (it.channel >= CHANNELS) begin
          r.status = ST_BAD;
        end else begin
          mdl_slot_ch[mdl_slots]  = it.channel;
          mdl_slot_fsh[mdl_slots] = it.filter_shift;
          mdl_out_sh[it.channel]  = it.out_shift;
          mdl_slots++;
        end
      end
      ACT_SAMPLE: begin
        p = mdl_pos;
        c = mdl_slot_ch[p];
        x = longint'(it.sample) << SAMPLE_POS;
        a = longint'(mdl_acc[c]);
        a = a + ((x - a) >>> mdl_slot_fsh[p]);
        if (a < 0) a = 0;
        if (a > 64'h7FFF_FFFF) a = 64'h7FFF_FFFF;
        mdl_acc[c] = a[VAL_W-1:0];
        p++;
        if (p >= mdl_slots || p >= CHANNELS) p = 0;
        mdl_pos = p;
        r.next_channel = mdl_slot_ch[p];
      end
      ACT_READ: begin
        if (it.channel >= CHANNELS) r.status = ST_BAD;
        else r.value = mdl_acc[it.channel] >> mdl_out_sh[it.channel];
      end
      default: ;
    endcase
    return r;
  endfunction

  // cycle count, input accept tracking, prediction, result check
  always @(posedge clk) begin
    result_t got;
    result_t want;
    cyc = cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      in_fire = rst_n && in_tvalid && in_tready;
      if (in_fire) begin
        expected_results.push_back(predict_scan(item_t'({in_tuser, in_tdata[26:0]})));
      end
      if (rst_n && out_tvalid && out_tready) begin
        got = result_t'(out_tdata[ST_W+VAL_W+CH_W-1:0]);
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: next_channel=%0d value=%0d status=%0d",
                     got.next_channel, got.value, got.status);
        end else begin
          want = expected_results.pop_front();
          if (got.next_channel !== want.next_channel || got.value !== want.value ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp next_channel=%0d value=%0d status=%0d, got %0d %0d %0d",
                       want.next_channel, want.value, want.status,
                       got.next_channel, got.value, got.status);
          end
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        drv_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= drv_item.action;
        in_tdata  <= {5'b0, drv_item.out_shift, drv_item.filter_shift,
                      drv_item.channel, drv_item.sample};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result-side ready, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && cyc >= HOLD_START) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 9);
    end
  end

  initial begin
    item_t it;
    int unsigned r;
    for (int i = 0; i < CHANNELS; i++) begin
      mdl_slot_ch[i]  = '0;
      mdl_slot_fsh[i] = FSH_RST;
      mdl_out_sh[i]   = OSH_RST;
      mdl_acc[i]      = '0;
    end
    mdl_slots = 0;
    mdl_pos   = 0;

    // empty table: samples land in slot 0 as reset
    pending_items.push_back(make_item(ACT_SAMPLE, 4095, 7, 31, 31));
    pending_items.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 0));
    pending_items.push_back(make_item(ACT_READ, 0, 0, 0, 0));
    pending_items.push_back(make_item(ACT_READ, 0, 17, 0, 0));
    pending_items.push_back(make_item(ACT_READ, 0, 18, 0, 0));
    pending_items.push_back(make_item(ACT_READ, 4095, 31, 31, 31));
    pending_items.push_back(make_item(ACT_ADD, 0, 31, 5, 5));
    pending_items.push_back(make_item(ACT_ADD, 0, 18, 5, 5));
    pending_items.push_back(make_item(ACT_NOP, 4095, 31, 31, 31));
    // fill the table; slots 0 and 1 share a channel to drive both shift extremes
    pending_items.push_back(make_item(ACT_ADD, 0, 3, 0, 0));
    pending_items.push_back(make_item(ACT_ADD, 0, 3, 31, 0));
    pending_items.push_back(make_item(ACT_ADD, 0, 0, 2, 31));
    pending_items.push_back(make_item(ACT_ADD, 0, 17, 4, 16));
    for (int i = 4; i < CHANNELS; i++)
      pending_items.push_back(make_item(ACT_ADD, 0, i - 3 + (i >= 6), $urandom_range(0, 12),
                                        $urandom_range(0, 31)));
    pending_items.push_back(make_item(ACT_SAMPLE, 4095, 0, 0, 0));
    pending_items.push_back(make_item(ACT_SAMPLE, 0, 0, 0, 0));
    pending_items.push_back(make_item(ACT_READ, 0, 3, 0, 0));
    pending_items.push_back(make_item(ACT_ADD, 0, 4, 1, 1));
    pending_items.push_back(make_item(ACT_ADD, 0, 18, 1, 1));

    for (int n = 0; n < RAND_ITEMS; n++) begin
      it = item_t'($urandom);
      r  = $urandom_range(0, 99);
      if (r < 55) begin
        it.action = ACT_SAMPLE;
        r = $urandom_range(0, 9);
        if (r == 0) it.sample = '0;
        else if (r == 1) it.sample = '1;
      end else if (r < 90) begin
        it.action = ACT_READ;
        if ($urandom_range(0, 9) != 0) it.channel = CH_W'($urandom_range(0, CHANNELS - 1));
      end else if (r < 95) begin
        it.action = ACT_ADD;
      end else begin
        it.action = ACT_NOP;
      end
      pending_items.push_back(it);
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
